FILE: sv/rpip_pkg.sv
package rpip_pkg;

  localparam int CharW  = 8;
  localparam int ValueW = 32;
  localparam int MagW   = 33;
  // Widest shift-add product: a 33-bit magnitude times sixteen plus a digit.
  localparam int ProdW  = MagW + 4;

  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;

  localparam logic [ProdW-1:0] LIMIT_POS = ProdW'(64'h7FFF_FFFF);
  localparam logic [ProdW-1:0] LIMIT_NEG = ProdW'(64'h8000_0000);

  // Digit value that marks a character which is no digit of any base.
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_BASE  = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_BIG = 2'd2
  } status_t;

  typedef struct packed {
    phase_t           phase;
    logic             is_negative;
    base_t            base_code;
    logic [MagW-1:0]  magnitude;
    logic [1:0]       digit_count;
    logic             leading_zero;
    logic             bad_token;
    logic             too_big;
  } tok_state_t;

  localparam tok_state_t TOK_RESET = '{
    phase:        PH_START,
    is_negative:  1'b0,
    base_code:    BASE_BIN,
    magnitude:    '0,
    digit_count:  2'd0,
    leading_zero: 1'b0,
    bad_token:    1'b0,
    too_big:      1'b0
  };

  function automatic logic is_base_letter(input logic [CharW-1:0] c);
    logic ok;
    case (c) inside
      8'h62, 8'h42, 8'h6F, 8'h4F, 8'h64, 8'h44, 8'h78, 8'h58: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic base_t base_of_letter(input logic [CharW-1:0] c);
    base_t b;
    case (c) inside
      8'h6F, 8'h4F: b = BASE_OCT;
      8'h64, 8'h44: b = BASE_DEC;
      8'h78, 8'h58: b = BASE_HEX;
      default:      b = BASE_BIN;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] digit_value(input logic [CharW-1:0] c);
    logic [4:0] d;
    case (c) inside
      [8'h30:8'h39]: d = 5'(c - CHAR_ZERO);
      [8'h61:8'h66]: d = 5'(c - 8'h57);
      [8'h41:8'h46]: d = 5'(c - 8'h37);
      default:       d = DIGIT_NONE;
    endcase
    return d;
  endfunction

  function automatic logic digit_fits(input base_t b, input logic [4:0] d);
    logic ok;
    case (b)
      BASE_BIN: ok = (d < 5'd2);
      BASE_OCT: ok = (d < 5'd8);
      BASE_DEC: ok = (d < 5'd10);
      BASE_HEX: ok = (d < 5'd16);
      default:  ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: sv/rpip_step.sv
module rpip_step
  import rpip_pkg::*;
(
  input  tok_state_t              cur,
  input  logic [CharW-1:0]        char_code,
  input  logic                    last_char,
  output tok_state_t              nxt,
  output logic signed [ValueW-1:0] res_value,
  output status_t                 res_status
);

  logic [4:0]       dval;
  logic             dec_zero_first;
  logic [ProdW-1:0] mag_ext;
  logic [ProdW-1:0] product;
  logic [ProdW-1:0] limit;
  tok_state_t       upd;

  assign dval           = digit_value(char_code);
  assign dec_zero_first = (cur.digit_count == 2'd0) && (dval == 5'd0);
  assign mag_ext        = ProdW'(cur.magnitude);
  assign limit          = cur.is_negative ? LIMIT_NEG : LIMIT_POS;

  // Constant-radix multiply as shifts and adds, then the digit is added.
  always_comb begin
    case (cur.base_code)
      BASE_BIN: product = (mag_ext << 1);
      BASE_OCT: product = (mag_ext << 3);
      BASE_DEC: product = (mag_ext << 3) + (mag_ext << 1);
      BASE_HEX: product = (mag_ext << 4);
      default:  product = '0;
    endcase
    product = product + ProdW'(dval);
  end

  always_comb begin
    upd = cur;
    if (!cur.bad_token) begin
      if (cur.phase == PH_START && char_code == CHAR_MINUS) begin
        upd.is_negative = 1'b1;
        upd.phase       = PH_BASE;
      end else if (cur.phase == PH_START || cur.phase == PH_BASE) begin
        if (is_base_letter(char_code)) begin
          upd.base_code = base_of_letter(char_code);
          upd.phase     = PH_DIGIT;
        end else begin
          upd.bad_token = 1'b1;
        end
      end else if (!digit_fits(cur.base_code, dval)) begin
        upd.bad_token = 1'b1;
      end else if (cur.base_code == BASE_DEC && !dec_zero_first && cur.leading_zero) begin
        // A decimal number may not go on after a leading zero.
        upd.bad_token = 1'b1;
      end else begin
        if (cur.base_code == BASE_DEC && dec_zero_first) begin
          upd.leading_zero = 1'b1;
        end
        if (cur.digit_count != 2'd2) begin
          upd.digit_count = cur.digit_count + 2'd1;
        end
        // Once out of range the magnitude is frozen.
        if (!cur.too_big) begin
          upd.magnitude = product[MagW-1:0];
          if (product > limit) begin
            upd.too_big = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    res_value = '0;
    if (upd.bad_token || upd.phase != PH_DIGIT || upd.digit_count == 2'd0) begin
      res_status = ST_BAD;
    end else if (upd.too_big) begin
      res_status = ST_BIG;
    end else begin
      res_status = ST_OK;
      res_value  = upd.is_negative ? -upd.magnitude[ValueW-1:0] : upd.magnitude[ValueW-1:0];
    end
    nxt = last_char ? TOK_RESET : upd;
  end

endmodule

FILE: sv/radix_prefixed_integer_parser_core.sv
// A last character is held in the input register (s1_char_r, s1_last_r); its result word
// is then written into the result register that drives out_*.
// Throughput: one character per cycle; only a last character waits, and only while
// the result register holds an untaken word.
// Reset (rst_n low, synchronous) returns the token state to expecting a sign or
// base letter and empties the input and result registers.
module radix_prefixed_integer_parser_core
  import rpip_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CharW-1:0]         in_char_code,
  input  logic                     in_last_char,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ValueW-1:0] out_value,
  output logic [1:0]               out_status
);

  logic                     s1_valid_r;
  logic                     s1_valid_nxt;
  logic [CharW-1:0]         s1_char_r;
  logic                     s1_last_r;
  logic                     s1_fire;
  tok_state_t               tok_r;
  tok_state_t               tok_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [ValueW-1:0] out_value_r;
  logic [1:0]               out_status_r;
  logic signed [ValueW-1:0] res_value;
  status_t                  res_status;

  rpip_step u_step (
    .cur        (tok_r),
    .char_code  (s1_char_r),
    .last_char  (s1_last_r),
    .nxt        (tok_nxt),
    .res_value  (res_value),
    .res_status (res_status)
  );

  // Only a last character needs room in the result register.
  assign in_stall = s1_valid_r && s1_last_r && out_valid_r && out_stall;
  assign s1_fire  = s1_valid_r && !in_stall;

  always_comb begin
    s1_valid_nxt = in_stall ? s1_valid_r : in_valid;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tok_r       <= TOK_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        tok_r <= tok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last_char;
    end
    if (s1_fire && s1_last_r) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

`ifndef ASSERT_OFF
  a_value_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_OK || out_value_r == '0))
    else $error("result word carries a value with a failing status");

  a_token_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> tok_r == TOK_RESET)
    else $error("token state not cleared after a last character");

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r && out_valid_r)
    else $error("input stalled without a pending result");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_OK || out_status_r == ST_BAD
                     || out_status_r == ST_BIG))
    else $error("illegal result status");
`endif

endmodule
